@@ hw/rtl/rsw_pkg.sv @@
`timescale 1ns / 1ps

package rsw_pkg;

    localparam logic [1:0] KIND_DELIVER = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_NACK    = 2'd2;

    localparam logic [7:0] WINDOW_BASE_RESET = 8'd31;

    typedef struct packed {
        logic        decode_ok;
        logic [7:0]  seq_number;
        logic [9:0]  payload_length;
        logic        truncated;
        logic [31:0] timestamp;
        logic [15:0] payload_handle;
    } pkt_word_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [15:0] deliver_handle;
        logic [9:0]  deliver_length;
        logic [7:0]  resp_seqnum;
        logic [7:0]  resp_window;
        logic [31:0] resp_timestamp;
        logic        transfer_done;
        logic        last;
    } resp_word_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [9:0]  length;
    } slot_word_t;

    typedef struct packed {
        logic latch;
        logic ts_upd;
        logic store;
        logic rd;
        logic deliver;
        logic resp;
    } ctrl_cmd_t;

    typedef struct packed {
        logic decode_ok;
        logic in_window;
        logic trunc;
        logic slot_busy;
        logic head_valid;
        logic out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/rsw_ifs.sv @@
`timescale 1ns / 1ps

interface rsw_pkt_if;
    import rsw_pkg::*;
    logic      valid;
    logic      ready;
    pkt_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rsw_resp_if;
    import rsw_pkg::*;
    logic       valid;
    logic       ready;
    resp_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rsw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/selective_repeat_receive_window.sv @@
`timescale 1ns / 1ps

// Selective-repeat receive window.
// pkt  : one decoded packet per word (valid/ready). Bad decodes and packets
//        outside the acceptance window are dropped with no result.
// resp : result words (valid/ready). Per accepted in-window packet: zero or
//        more in-order deliveries (kind 0), then one ACK or NACK with last=1.
// cfg  : write of window_base; reloads the advertised free-slot count.
//        Write only while the block is idle.
// Flow: a packet is taken only in idle. For a dropped packet the control
// returns to idle after evaluation; a NACK or a duplicate's ACK goes through
// evaluation and the response state; a stored packet drains its in-order
// slots, each read via the registered slot memory port and then delivered.
// Results sit in an output register, so a stalled resp channel holds the
// current word and pauses the drain.
// Reset: window empty, next expected number 0, timestamp 0, window_base 31.
// Buffer slot contents are not cleared; only their valid bits are.
module selective_repeat_receive_window #(
    parameter int SLOTS       = 32,
    parameter int ACCEPT_SPAN = 31,
    parameter int SEQ_MODULUS = 256
) (
    input logic         clk,
    input logic         rst_n,
    rsw_pkt_if.sink     pkt,
    rsw_resp_if.source  resp,
    rsw_cfg_if.sink     cfg
);
    import rsw_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       ctrl_ready;

    assign pkt.ready = ctrl_ready;
    assign cfg.ready = 1'b1;

    rsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt.valid),
        .pkt_ready (ctrl_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rsw_dp #(
        .SLOTS       (SLOTS),
        .ACCEPT_SPAN (ACCEPT_SPAN),
        .SEQ_MODULUS (SEQ_MODULUS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_data   (pkt.data),
        .cfg_wr     (cfg.valid),
        .cfg_data   (cfg.data),
        .cmd        (cmd),
        .status     (status),
        .resp_valid (resp.valid),
        .resp_data  (resp.data),
        .resp_ready (resp.ready)
    );

endmodule

@@ hw/rtl/rsw_ctrl.sv @@
`timescale 1ns / 1ps

module rsw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    output logic                pkt_ready,
    input  rsw_pkg::dp_status_t status,
    output rsw_pkg::ctrl_cmd_t  cmd
);
    import rsw_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_DELIV = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        pkt_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pkt_ready = 1'b1;
                if (pkt_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!status.decode_ok)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.ts_upd = 1'b1;
                    if (!status.in_window)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.trunc || status.slot_busy)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        cmd.store  = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (status.head_valid)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_DELIV;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_DELIV:
            begin
                if (status.out_free)
                begin
                    cmd.deliver = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.resp   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_deliver_from_deliv : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deliver |-> $past(state_reg) == ST_READ || $past(state_reg) == ST_DELIV)
        else $error("deliver issued outside the drain loop");
    a_store_then_read : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> state_reg == ST_READ)
        else $error("store not followed by head read");
    a_ready_idle_only : assert property (@(posedge clk) disable iff (!rst_n)
        pkt_ready |-> !cmd.resp && !cmd.deliver && !cmd.store)
        else $error("packet accepted while an item is in work");

endmodule

@@ hw/rtl/rsw_dp.sv @@
`timescale 1ns / 1ps

module rsw_dp #(
    parameter int SLOTS       = 32,
    parameter int ACCEPT_SPAN = 31,
    parameter int SEQ_MODULUS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rsw_pkg::pkt_word_t  pkt_data,
    input  logic                cfg_wr,
    input  logic [7:0]          cfg_data,
    input  rsw_pkg::ctrl_cmd_t  cmd,
    output rsw_pkg::dp_status_t status,
    output logic                resp_valid,
    output rsw_pkg::resp_word_t resp_data,
    input  logic                resp_ready
);
    import rsw_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int UW = $clog2(SLOTS + 1);

    typedef logic [IW-1:0] mod_tab_t [256];

    function automatic mod_tab_t build_mod_tab();
        mod_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = IW'(i % SLOTS);
        end
        return t;
    endfunction

    localparam mod_tab_t MOD_TAB = build_mod_tab();

    pkt_word_t        pkt_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [UW-1:0]    used_reg;
    logic [7:0]       base_reg;
    logic [7:0]       ne_reg;
    logic [7:0]       ne_next;
    logic [31:0]      ts_reg;
    logic             done_reg;
    slot_word_t       rd_reg;
    resp_word_t       out_reg;
    logic             out_valid_reg;
    slot_word_t       mem [SLOTS];

    logic [IW-1:0] slot_idx;
    logic [IW-1:0] head_idx;
    logic [8:0]    diff;
    logic [8:0]    offset;
    logic [7:0]    window;

    assign slot_idx = MOD_TAB[pkt_reg.seq_number];
    assign head_idx = MOD_TAB[ne_reg];
    assign diff     = {1'b0, pkt_reg.seq_number} - {1'b0, ne_reg};
    assign offset   = diff[8] ? diff + 9'(SEQ_MODULUS) : diff;
    assign window   = base_reg - 8'(used_reg);
    assign ne_next  = (ne_reg == 8'(SEQ_MODULUS - 1)) ? 8'd0 : ne_reg + 8'd1;

    always_comb
    begin
        status.decode_ok  = pkt_reg.decode_ok;
        status.in_window  = ({1'b0, pkt_reg.seq_number} < 9'(SEQ_MODULUS))
                            && (offset < 9'(ACCEPT_SPAN));
        status.trunc      = pkt_reg.truncated;
        status.slot_busy  = valid_reg[slot_idx];
        status.head_valid = valid_reg[head_idx];
        status.out_free   = !out_valid_reg || resp_ready;
    end

    assign resp_valid = out_valid_reg;
    assign resp_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            pkt_reg <= pkt_data;
        end
        if (cmd.store)
        begin
            mem[slot_idx] <= '{handle: pkt_reg.payload_handle,
                               length: pkt_reg.payload_length};
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[head_idx];
        end
        if (cmd.deliver)
        begin
            out_reg <= '{out_kind: KIND_DELIVER, deliver_handle: rd_reg.handle,
                         deliver_length: rd_reg.length, default: '0};
        end
        else if (cmd.resp)
        begin
            out_reg.out_kind       <= pkt_reg.truncated ? KIND_NACK : KIND_ACK;
            out_reg.deliver_handle <= '0;
            out_reg.deliver_length <= '0;
            out_reg.resp_seqnum    <= pkt_reg.truncated ? pkt_reg.seq_number : ne_reg;
            out_reg.resp_window    <= window;
            out_reg.resp_timestamp <= ts_reg;
            out_reg.transfer_done  <= done_reg;
            out_reg.last           <= 1'b1;
        end
        if (cmd.ts_upd)
        begin
            done_reg <= (pkt_reg.payload_length == 10'd0) && (pkt_reg.seq_number == ne_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            used_reg      <= '0;
            base_reg      <= WINDOW_BASE_RESET;
            ne_reg        <= '0;
            ts_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                base_reg <= cfg_data;
            end
            if (cmd.ts_upd)
            begin
                ts_reg <= pkt_reg.timestamp;
            end
            if (cmd.store)
            begin
                valid_reg[slot_idx] <= 1'b1;
                used_reg            <= used_reg + UW'(1);
            end
            else if (cmd.deliver)
            begin
                valid_reg[head_idx] <= 1'b0;
                used_reg            <= used_reg - UW'(1);
                ne_reg              <= ne_next;
            end
            if (cmd.deliver || cmd.resp)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (resp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_store_free_slot : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !valid_reg[slot_idx])
        else $error("store into an occupied slot");
    a_deliver_valid : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deliver |-> valid_reg[head_idx] && used_reg != '0)
        else $error("delivery from an empty slot");
    a_used_bound : assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(SLOTS) && 32'($countones(valid_reg)) == 32'(used_reg))
        else $error("occupancy count out of step with valid bits");
    a_resp_last : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resp |=> out_valid_reg && out_reg.last && out_reg.out_kind != KIND_DELIVER)
        else $error("response word not marked last");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import rsw_pkg::*;

    localparam int SLOTS        = 32;
    localparam int ACCEPT_SPAN  = 31;
    localparam int SEQ_MODULUS  = 256;
    localparam int IDLE_PCT     = 13;
    localparam int QUIET_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;

    logic clk;
    logic rst_n;
    logic calm;

    rsw_pkt_if  pkt ();
    rsw_resp_if resp ();
    rsw_cfg_if  cfg ();

    selective_repeat_receive_window #(
        .SLOTS       (SLOTS),
        .ACCEPT_SPAN (ACCEPT_SPAN),
        .SEQ_MODULUS (SEQ_MODULUS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .resp  (resp),
        .cfg   (cfg)
    );

    // receive-window shadow
    logic        slot_busy [SLOTS];
    logic [15:0] slot_tag [SLOTS];
    logic [9:0]  slot_len [SLOTS];
    logic [7:0]  pred_next;
    logic [7:0]  pred_free;
    logic [31:0] pred_ts;
    logic        next_wrapped;

    pkt_word_t  pkt_backlog [$];
    resp_word_t pending_resp [$];
    int         pushed_cnt;
    int         accepted_cnt;
    int         mismatches;
    int         quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic pkt_word_t mk_pkt(input logic ok, input logic [7:0] seq,
                                         input logic [9:0] len, input logic trunc,
                                         input logic [31:0] ts, input logic [15:0] tag);
        pkt_word_t w;
        w.decode_ok      = ok;
        w.seq_number     = seq;
        w.payload_length = len;
        w.truncated      = trunc;
        w.timestamp      = ts;
        w.payload_handle = tag;
        return w;
    endfunction

    function automatic void send_pkt(input pkt_word_t w);
        pkt_backlog.push_back(w);
        pushed_cnt++;
    endfunction

    function automatic void predict_window(input pkt_word_t p);
        resp_word_t r;
        logic [7:0] offset;
        int         idx;
        if (!p.decode_ok)
            return;
        pred_ts = p.timestamp;
        offset  = p.seq_number - pred_next;
        if (offset >= ACCEPT_SPAN)
            return;
        r               = '0;
        r.transfer_done = (p.payload_length == 10'd0) && (p.seq_number == pred_next);
        r.last          = 1'b1;
        if (p.truncated)
        begin
            r.out_kind       = KIND_NACK;
            r.resp_seqnum    = p.seq_number;
            r.resp_window    = pred_free;
            r.resp_timestamp = pred_ts;
            pending_resp.push_back(r);
            return;
        end
        idx = p.seq_number % SLOTS;
        if (!slot_busy[idx])
        begin
            slot_busy[idx] = 1'b1;
            slot_tag[idx]  = p.payload_handle;
            slot_len[idx]  = p.payload_length;
            pred_free--;
            idx = pred_next % SLOTS;
            while (slot_busy[idx])
            begin
                resp_word_t d;
                d                = '0;
                d.out_kind       = KIND_DELIVER;
                d.deliver_handle = slot_tag[idx];
                d.deliver_length = slot_len[idx];
                pending_resp.push_back(d);
                slot_busy[idx] = 1'b0;
                pred_free++;
                if (pred_next == 8'hFF)
                    next_wrapped = 1'b1;
                pred_next++;
                idx = (idx + 1) % SLOTS;
            end
        end
        r.out_kind       = KIND_ACK;
        r.resp_seqnum    = pred_next;
        r.resp_window    = pred_free;
        r.resp_timestamp = pred_ts;
        pending_resp.push_back(r);
    endfunction

    function automatic void reload_window(input logic [7:0] base);
        int used;
        used = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_busy[i])
                used++;
        pred_free = 8'(base - used);
    endfunction

    function automatic void check_resp(input resp_word_t got);
        resp_word_t want;
        if (pending_resp.size() == 0)
        begin
            $error("unexpected result word, kind %0d", got.out_kind);
            mismatches++;
            return;
        end
        want = pending_resp.pop_front();
        if (got.out_kind !== want.out_kind)
        begin
            $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
            mismatches++;
        end
        if (got.deliver_handle !== want.deliver_handle)
        begin
            $error("deliver_handle: expected %0h, got %0h", want.deliver_handle,
                   got.deliver_handle);
            mismatches++;
        end
        if (got.deliver_length !== want.deliver_length)
        begin
            $error("deliver_length: expected %0d, got %0d", want.deliver_length,
                   got.deliver_length);
            mismatches++;
        end
        if (got.resp_seqnum !== want.resp_seqnum)
        begin
            $error("resp_seqnum: expected %0d, got %0d", want.resp_seqnum, got.resp_seqnum);
            mismatches++;
        end
        if (got.resp_window !== want.resp_window)
        begin
            $error("resp_window: expected %0d, got %0d", want.resp_window, got.resp_window);
            mismatches++;
        end
        if (got.resp_timestamp !== want.resp_timestamp)
        begin
            $error("resp_timestamp: expected %0h, got %0h", want.resp_timestamp,
                   got.resp_timestamp);
            mismatches++;
        end
        if (got.transfer_done !== want.transfer_done)
        begin
            $error("transfer_done: expected %0d, got %0d", want.transfer_done,
                   got.transfer_done);
            mismatches++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatches++;
        end
    endfunction

    // packet driver
    always @(posedge clk)
    begin
        if (!rst_n)
            pkt.valid <= 1'b0;
        else if (!pkt.valid || pkt.ready)
        begin
            if (pkt_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                pkt.valid <= 1'b1;
                pkt.data  <= pkt_backlog.pop_front();
            end
            else
                pkt.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            resp.ready <= 1'b0;
        else
            resp.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor, scoreboard and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (resp.valid && resp.ready)
                check_resp(resp.data);
            if (pkt.valid && pkt.ready)
            begin
                predict_window(pkt.data);
                accepted_cnt++;
            end
            if (cfg.valid && cfg.ready)
                reload_window(cfg.data);
            if ((resp.valid && resp.ready) || (pkt.valid && pkt.ready)
                || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_quiet();
        do
            @(posedge clk);
        while (accepted_cnt != pushed_cnt || pending_resp.size() != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [7:0] base);
        cfg.valid <= 1'b1;
        cfg.data  <= base;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // one run of sequence numbers from the current expected number, with noise mixed in
    task automatic queue_burst();
        logic [7:0] base;
        logic [7:0] seqs [SLOTS];
        logic [7:0] swap;
        pkt_word_t  w;
        int         k;
        int         mode;
        int         pick;
        while (accepted_cnt != pushed_cnt)
            @(posedge clk);
        base = pred_next;
        mode = $urandom_range(0, 99);
        if (mode < 50)
            k = $urandom_range(1, 6);
        else if (mode < 85)
            k = $urandom_range(2, 8);
        else
            k = ($urandom_range(0, 3) == 0) ? ACCEPT_SPAN : $urandom_range(2, ACCEPT_SPAN);
        for (int j = 0; j < k; j++)
            seqs[j] = (mode < 85) ? 8'(base + j) : 8'(base + k - 1 - j);
        if (mode >= 50 && mode < 85)
        begin
            for (int j = k - 1; j > 0; j--)
            begin
                pick       = $urandom_range(0, j);
                swap       = seqs[j];
                seqs[j]    = seqs[pick];
                seqs[pick] = swap;
            end
        end
        for (int j = 0; j < k; j++)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                w = mk_pkt(1'b1, 8'(base + $urandom_range(0, ACCEPT_SPAN - 1)),
                           10'($urandom_range(0, 1023)), 1'b0, $urandom, 16'($urandom));
                case ($urandom_range(0, 3))
                    0:
                    begin
                        w.decode_ok  = 1'b0;
                        w.seq_number = 8'($urandom);
                        w.truncated  = 1'($urandom_range(0, 1));
                    end
                    1:
                    begin
                        w.seq_number = 8'(base + $urandom_range(ACCEPT_SPAN, 255));
                        w.truncated  = 1'($urandom_range(0, 1));
                    end
                    2:
                        w.truncated = 1'b0;
                    default:
                    begin
                        w.truncated = 1'b1;
                        if ($urandom_range(0, 2) == 0)
                            w.payload_length = 10'd0;
                    end
                endcase
                send_pkt(w);
            end
            send_pkt(mk_pkt(1'b1, seqs[j],
                            ($urandom_range(0, 19) == 0) ? 10'd0
                                                         : 10'($urandom_range(0, 1023)),
                            1'b0, $urandom, 16'($urandom)));
        end
    endtask

    initial
    begin
        int next_cfg_at;
        rst_n        = 1'b0;
        calm         = 1'b0;
        pkt.valid    = 1'b0;
        pkt.data     = '0;
        resp.ready   = 1'b0;
        cfg.valid    = 1'b0;
        cfg.data     = '0;
        pred_next    = 8'd0;
        pred_free    = WINDOW_BASE_RESET;
        pred_ts      = 32'd0;
        next_wrapped = 1'b0;
        pushed_cnt   = 0;
        accepted_cnt = 0;
        mismatches   = 0;
        quiet_cycles = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_tag[i]  = '0;
            slot_len[i]  = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bad decode, extremes, window edges, duplicate, end markers
        send_pkt(mk_pkt(1'b0, 8'hFF, 10'h3FF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF));
        send_pkt(mk_pkt(1'b1, 8'd0, 10'h3FF, 1'b0, 32'hFFFF_FFFF, 16'hFFFF));
        send_pkt(mk_pkt(1'b1, 8'd1, 10'd0, 1'b1, 32'd1, 16'h0001));
        send_pkt(mk_pkt(1'b1, 8'd32, 10'd5, 1'b0, 32'd2, 16'h0002));
        send_pkt(mk_pkt(1'b1, 8'd0, 10'd5, 1'b0, 32'd3, 16'h0003));
        send_pkt(mk_pkt(1'b1, 8'd31, 10'd512, 1'b0, 32'h8000_0000, 16'h1234));
        send_pkt(mk_pkt(1'b1, 8'd31, 10'd9, 1'b0, 32'd4, 16'hBEEF));
        send_pkt(mk_pkt(1'b1, 8'd2, 10'd7, 1'b0, 32'd5, 16'h5555));
        send_pkt(mk_pkt(1'b1, 8'd1, 10'd0, 1'b0, 32'd6, 16'h0000));
        send_pkt(mk_pkt(1'b1, 8'd3, 10'd0, 1'b0, 32'd0, 16'h0000));
        send_pkt(mk_pkt(1'b1, 8'd4, 10'd512, 1'b1, 32'd7, 16'hAAAA));
        send_pkt(mk_pkt(1'b1, 8'hFF, 10'h3FF, 1'b0, 32'd8, 16'h00FF));
        wait_quiet();

        write_window(8'd0);
        repeat (3) queue_burst();
        wait_quiet();
        write_window(8'd255);
        repeat (3) queue_burst();

        next_cfg_at = pushed_cnt + 70;
        while (pushed_cnt < 280 || !next_wrapped)
        begin
            calm = (pushed_cnt >= 120 && pushed_cnt < 180);
            queue_burst();
            if (pushed_cnt >= next_cfg_at)
            begin
                wait_quiet();
                write_window(8'($urandom));
                next_cfg_at = pushed_cnt + 70;
            end
        end
        calm = 1'b0;
        wait_quiet();

        if (mismatches == 0 && pending_resp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
